@@ src/grid_proximity_tracker_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the grid proximity tracker
// Shared macros for writing clocked concurrent assertions with a reset guard.
// ----------------------------------------------------------------------------
`ifndef GRID_PROXIMITY_TRACKER_CORE_DEFINES_SVH
`define GRID_PROXIMITY_TRACKER_CORE_DEFINES_SVH

// A property checked at every rising edge, disabled while reset is high.
`define GPROX_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("gprox: property violated");

// A condition that must be followed by a consequence in the next cycle.
`define GPROX_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  `GPROX_ASSERT(lbl, ck, rs, (ante) |=> (cons))

`endif

@@ src/gprox_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid proximity tracker package
// Sizes, opcodes, status codes, payload types and controller interface types.
// ----------------------------------------------------------------------------
package gprox_pkg;

  localparam int TABLE_SLOTS   = 32;
  localparam int FRACTION_BITS = 8;
  localparam int POS_W         = 24;
  localparam int ID_W          = 16;
  localparam int SNAP_SHIFT    = FRACTION_BITS - 2;
  localparam int CELL_W        = POS_W - SNAP_SHIFT;
  localparam int SLOT_W        = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W         = $clog2(TABLE_SLOTS + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_REMOVED = 3'd2;
  localparam logic [2:0] ST_HIT     = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [ID_W-1:0]         object_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    last_place;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [ID_W-1:0] found_id;
    logic            last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADD,
    S_REMOVE,
    S_SCAN,
    S_PICK,
    S_EMIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       add;
    logic       remove;
    logic       scan;
    logic       pick;
    logic       emit;
    logic       resp_set;
    logic [2:0] resp_code;
    logic       resp_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       last_place;
    logic       free_any;
    logic       scan_done;
    logic       mask_zero;
    logic       emit_last;
    logic       out_free;
  } dp_status_t;

endpackage

@@ src/gprox_ctrl.sv @@
// ----------------------------------------------------------------------------
// Grid proximity tracker controller
// Sequences request capture, table updates, the slot scan and result emission.
// ----------------------------------------------------------------------------
module gprox_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  gprox_pkg::dp_status_t  sts,
  output gprox_pkg::ctrl_cmd_t   cmd
);
  import gprox_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_ADD:    state_next = S_ADD;
          OP_REMOVE: state_next = S_REMOVE;
          OP_QUERY:  state_next = S_SCAN;
          default:   state_next = S_IDLE;
        endcase
      end
      S_ADD:    state_next = S_RESP;
      S_REMOVE: state_next = S_RESP;
      S_SCAN: begin
        if (sts.scan_done) state_next = sts.last_place ? S_PICK : S_IDLE;
      end
      S_PICK: begin
        state_next = sts.mask_zero ? S_RESP : S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_next = sts.emit_last ? S_IDLE : S_PICK;
      end
      S_RESP: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_DECODE: begin
      end
      S_ADD: begin
        cmd.add       = 1'b1;
        cmd.resp_set  = 1'b1;
        cmd.resp_code = sts.free_any ? ST_ADDED : ST_FULL;
      end
      S_REMOVE: begin
        cmd.remove    = 1'b1;
        cmd.resp_set  = 1'b1;
        cmd.resp_code = ST_REMOVED;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_PICK: begin
        cmd.pick      = 1'b1;
        cmd.resp_set  = sts.mask_zero;
        cmd.resp_code = ST_NONE;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
      end
      S_RESP: begin
        cmd.resp_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/gprox_datapath.sv @@
// ----------------------------------------------------------------------------
// Grid proximity tracker datapath
// Snaps positions, holds the slot table and cell memory, scans for nearby
// slots, deduplicates hits and drives the result register.
// ----------------------------------------------------------------------------
module gprox_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  gprox_pkg::in_item_t    req_item,
  input  logic                   res_ready,
  output logic                   res_valid,
  output gprox_pkg::out_item_t   res_item,
  input  gprox_pkg::ctrl_cmd_t   cmd,
  output gprox_pkg::dp_status_t  sts
);
  import gprox_pkg::*;

  // Quarter-unit snap: round to nearest with ties to even, saturating high.
  function automatic logic signed [CELL_W-1:0] snap_cell(input logic signed [POS_W-1:0] v);
    logic [POS_W:0]      wide;
    logic [CELL_W:0]     q;
    logic [CELL_W:0]     q_up;
    logic [SNAP_SHIFT:0] rem;
    logic [SNAP_SHIFT:0] half;
    logic                up;
    wide = {v, 1'b0};
    q    = {wide[POS_W], wide[POS_W:SNAP_SHIFT+1]};
    rem  = wide[SNAP_SHIFT:0];
    half = '0;
    half[SNAP_SHIFT] = 1'b1;
    up   = (rem > half) || ((rem == half) && q[0]);
    q_up = q + {{CELL_W{1'b0}}, up};
    if (q_up[CELL_W] != q_up[CELL_W-1]) begin
      snap_cell = {1'b0, {(CELL_W-1){1'b1}}};
    end else begin
      snap_cell = q_up[CELL_W-1:0];
    end
  endfunction

  function automatic logic near_cell(input logic [CELL_W-1:0] a, input logic [CELL_W-1:0] b);
    logic [CELL_W:0] d;
    d = {a[CELL_W-1], a} - {b[CELL_W-1], b};
    near_cell = (d == '0) || (d == {{CELL_W{1'b0}}, 1'b1}) || (d == '1);
  endfunction

  logic [1:0]               op_q;
  logic [ID_W-1:0]          id_q;
  logic                     last_q;
  logic [CELL_W-1:0]        qx;
  logic [CELL_W-1:0]        qy;
  logic [CELL_W-1:0]        qz;

  logic [TABLE_SLOTS-1:0]   slot_valid;
  logic [ID_W-1:0]          slot_id [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0]   hit_mask;
  logic [3*CELL_W-1:0]      cell_mem [TABLE_SLOTS];
  logic [3*CELL_W-1:0]      rd_data;
  logic [SLOT_W-1:0]        rd_idx;
  logic                     rd_live;
  logic [CNT_W-1:0]         cnt;
  logic [ID_W-1:0]          pick_id;
  logic [2:0]               resp_code;

  logic                     free_any;
  logic [SLOT_W-1:0]        free_idx;
  logic [SLOT_W-1:0]        pick_idx;
  logic [TABLE_SLOTS-1:0]   rm_match;
  logic [TABLE_SLOTS-1:0]   dup_match;
  logic [TABLE_SLOTS-1:0]   mask_after;
  logic                     scan_rd;
  logic                     near_hit;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    pick_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
      if (hit_mask[i]) begin
        pick_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      rm_match[i]  = slot_valid[i] && (slot_id[i] == id_q);
      dup_match[i] = (slot_id[i] == pick_id);
    end
  end

  assign mask_after = hit_mask & ~dup_match;
  assign scan_rd    = cnt < CNT_W'(TABLE_SLOTS);
  assign near_hit   = rd_live && slot_valid[rd_idx]
                      && near_cell(rd_data[3*CELL_W-1:2*CELL_W], qx)
                      && near_cell(rd_data[2*CELL_W-1:CELL_W], qy)
                      && near_cell(rd_data[CELL_W-1:0], qz);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= req_item.opcode;
      id_q   <= req_item.object_id;
      last_q <= req_item.last_place;
      qx     <= snap_cell(req_item.pos_x);
      qy     <= snap_cell(req_item.pos_y);
      qz     <= snap_cell(req_item.pos_z);
    end
    if (cmd.add && free_any) begin
      slot_id[free_idx]  <= id_q;
      cell_mem[free_idx] <= {qx, qy, qz};
    end
    if (cmd.scan && scan_rd) begin
      rd_data <= cell_mem[cnt[SLOT_W-1:0]];
      rd_idx  <= cnt[SLOT_W-1:0];
    end
    if (cmd.pick) begin
      pick_id <= slot_id[pick_idx];
    end
    if (cmd.resp_set) begin
      resp_code <= cmd.resp_code;
    end
    if (cmd.resp_load) begin
      res_item <= '{status: resp_code, found_id: '0, last_result: 1'b1};
    end else if (cmd.emit) begin
      res_item <= '{status: ST_HIT, found_id: pick_id, last_result: (mask_after == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      hit_mask   <= '0;
      cnt        <= '0;
      rd_live    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        cnt     <= '0;
        rd_live <= 1'b0;
      end else if (cmd.scan) begin
        rd_live <= scan_rd;
        if (scan_rd) cnt <= cnt + CNT_W'(1);
      end
      if (cmd.add) begin
        if (free_any) begin
          slot_valid[free_idx] <= 1'b1;
          hit_mask[free_idx]   <= 1'b0;
        end
      end else if (cmd.remove) begin
        slot_valid <= slot_valid & ~rm_match;
        hit_mask   <= hit_mask & ~rm_match;
      end else if (cmd.scan) begin
        if (near_hit) hit_mask[rd_idx] <= 1'b1;
      end else if (cmd.emit) begin
        hit_mask <= mask_after;
      end
      if (cmd.resp_load || cmd.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign sts = '{op: op_q,
                 last_place: last_q,
                 free_any: free_any,
                 scan_done: (cnt == CNT_W'(TABLE_SLOTS)),
                 mask_zero: (hit_mask == '0),
                 emit_last: (mask_after == '0),
                 out_free: (!res_valid || res_ready)};

endmodule

@@ src/grid_proximity_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Grid proximity tracker core
// Spatial hash grid that stores object ids at quarter-unit cells and reports
// the distinct ids within one cell of a run of query positions.
// ----------------------------------------------------------------------------
// One request is worked at a time. An add or a remove passes through decode and
// its table update, places its result in the output register and then takes the
// next request. Each query position walks the cell memory through its single
// read port, one slot per cycle, before the next request can be taken. On the
// last position of a list, each distinct id found is picked and then emitted,
// and a list with no hit gives one none result after its pick. A result that
// waits for the receiver holds the block until the output register is free. A
// new request is taken as soon as the last result sits in the output register,
// even if that result has not yet been taken.
module grid_proximity_tracker_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  gprox_pkg::in_item_t   req_item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output gprox_pkg::out_item_t  res_item
);
  import gprox_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  gprox_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gprox_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_item  (res_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ src/gprox_checker.sv @@
// ----------------------------------------------------------------------------
// Grid proximity tracker port checker
// Watches the top level ports for result hold, busy and result format rules.
// ----------------------------------------------------------------------------
`include "grid_proximity_tracker_core_defines.svh"

module gprox_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  res_valid,
  input logic                  res_ready,
  input gprox_pkg::out_item_t  res_item
);
  import gprox_pkg::*;

  `GPROX_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_item))
  `GPROX_ASSERT_NEXT(a_req_busy, clk, rst, req_valid && req_ready, !req_ready)
  `GPROX_ASSERT(a_id_zero, clk, rst, res_valid && (res_item.status != ST_HIT) |-> res_item.found_id == '0)
  `GPROX_ASSERT(a_single_last, clk, rst, res_valid && (res_item.status != ST_HIT) |-> res_item.last_result)

endmodule

bind grid_proximity_tracker_core gprox_checker u_gprox_checker (.*);

@@ tb/gprox_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Result checker for the grid proximity tracker
// Watches the request and result channels, keeps its own copy of the slot
// table and the hit marks, predicts the results of every accepted request and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module gprox_result_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  gprox_pkg::in_item_t  req_item,
  input  logic                 res_valid,
  input  logic                 res_ready,
  input  gprox_pkg::out_item_t res_item,
  output int                   fail_count,
  output int                   outstanding
);
  import gprox_pkg::*;

  localparam int MAX_REPORTS = 10;

  bit                     occupied   [TABLE_SLOTS];
  logic [ID_W-1:0]        slot_owner [TABLE_SLOTS];
  int                     slot_cx    [TABLE_SLOTS];
  int                     slot_cy    [TABLE_SLOTS];
  int                     slot_cz    [TABLE_SLOTS];
  bit [TABLE_SLOTS-1:0]   proximity_hits;
  out_item_t              expected_results[$];

  function automatic int snap_cell(logic signed [POS_W-1:0] p);
    int v;
    int q;
    int r;
    int hi;
    int lo;
    v  = int'(p);
    q  = v >>> SNAP_SHIFT;
    r  = v & ((1 << SNAP_SHIFT) - 1);
    hi = (1 << (CELL_W - 1)) - 1;
    lo = -hi - 1;
    if (r > (1 << (SNAP_SHIFT - 1)) || (r == (1 << (SNAP_SHIFT - 1)) && q[0])) begin
      q = q + 1;
    end
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q;
  endfunction

  function automatic bit is_near(int a, int b);
    return (a - b >= -1) && (a - b <= 1);
  endfunction

  function automatic out_item_t make_result(logic [2:0] st, logic [ID_W-1:0] id, logic last);
    out_item_t r;
    r.status      = st;
    r.found_id    = id;
    r.last_result = last;
    return r;
  endfunction

  task automatic queue_result(out_item_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic predict_request(in_item_t it);
    int        free_slot;
    int        qx;
    int        qy;
    int        qz;
    bit        repeated;
    logic [ID_W-1:0] found[$];
    free_slot = -1;
    case (it.opcode)
      OP_ADD: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!occupied[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot >= 0) begin
          occupied[free_slot]       = 1'b1;
          slot_owner[free_slot]     = it.object_id;
          slot_cx[free_slot]        = snap_cell(it.pos_x);
          slot_cy[free_slot]        = snap_cell(it.pos_y);
          slot_cz[free_slot]        = snap_cell(it.pos_z);
          proximity_hits[free_slot] = 1'b0;
          queue_result(make_result(ST_ADDED, '0, 1'b1));
        end else begin
          queue_result(make_result(ST_FULL, '0, 1'b1));
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (occupied[i] && slot_owner[i] == it.object_id) begin
            occupied[i]       = 1'b0;
            proximity_hits[i] = 1'b0;
          end
        end
        queue_result(make_result(ST_REMOVED, '0, 1'b1));
      end
      OP_QUERY: begin
        qx = snap_cell(it.pos_x);
        qy = snap_cell(it.pos_y);
        qz = snap_cell(it.pos_z);
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (occupied[i] && is_near(slot_cx[i], qx) && is_near(slot_cy[i], qy) &&
              is_near(slot_cz[i], qz)) begin
            proximity_hits[i] = 1'b1;
          end
        end
        if (it.last_place) begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (proximity_hits[i]) begin
              repeated = 1'b0;
              for (int j = 0; j < i; j++) begin
                if (proximity_hits[j] && slot_owner[j] == slot_owner[i]) repeated = 1'b1;
              end
              if (!repeated) found = {found, slot_owner[i]};
            end
          end
          proximity_hits = '0;
          if (found.size() == 0) begin
            queue_result(make_result(ST_NONE, '0, 1'b1));
          end else begin
            foreach (found[k]) begin
              queue_result(make_result(ST_HIT, found[k], k == found.size() - 1));
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      if (fail_count < MAX_REPORTS) begin
        $display("%0t: result with no request pending: status %0d id %h last %0b",
                 $realtime, got.status, got.found_id, got.last_result);
      end
      fail_count = fail_count + 1;
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status || got.found_id !== want.found_id ||
          got.last_result !== want.last_result) begin
        if (fail_count < MAX_REPORTS) begin
          $display("%0t: expected status %0d id %h last %0b, got status %0d id %h last %0b",
                   $realtime, want.status, want.found_id, want.last_result,
                   got.status, got.found_id, got.last_result);
        end
        fail_count = fail_count + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        occupied[i]   = 1'b0;
        slot_owner[i] = '0;
        slot_cx[i]    = 0;
        slot_cy[i]    = 0;
        slot_cz[i]    = 0;
      end
      proximity_hits = '0;
      expected_results.delete();
      fail_count  = 0;
      outstanding <= 0;
    end else begin
      if (res_valid && res_ready) check_result(res_item);
      if (req_valid && req_ready) predict_request(req_item);
      outstanding <= expected_results.size();
    end
  end

endmodule

@@ tb/tb_grid_proximity_tracker_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the grid proximity tracker core
// Sends a short directed run of adds, removes and query lists, then random
// requests clustered in space so that queries hit, in four flow-control
// phases. A separate checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_grid_proximity_tracker_core;
  import gprox_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_ITEMS  = 88;
  localparam int DRAIN_CYCLES = 4 * TABLE_SLOTS + 16;
  localparam int POOL_DEPTH   = 32;
  localparam logic signed [POS_W-1:0] POS_HI = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_LO = 24'sh800000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  in_item_t  req_item = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  out_item_t res_item;
  int        fail_count;
  int        outstanding;
  int        idle_pct = 0;
  int        stall_pct = 0;

  logic signed [POS_W-1:0] seen_x[$];
  logic signed [POS_W-1:0] seen_y[$];
  logic signed [POS_W-1:0] seen_z[$];

  grid_proximity_tracker_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  gprox_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_item    (req_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #20ms;
    $display("** grid_proximity_tracker_core: FAILED **");
    $finish;
  end

  function automatic in_item_t make_request(logic [1:0] op, logic [ID_W-1:0] id,
                                            logic signed [POS_W-1:0] x,
                                            logic signed [POS_W-1:0] y,
                                            logic signed [POS_W-1:0] z, logic last);
    in_item_t it;
    it.opcode     = op;
    it.object_id  = id;
    it.pos_x      = x;
    it.pos_y      = y;
    it.pos_z      = z;
    it.last_place = last;
    return it;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    logic [31:0] w;
    int sel;
    w   = $urandom;
    sel = $urandom_range(19);
    if (sel < 14) return ID_W'($urandom_range(11));
    if (sel < 18) return w[ID_W-1:0];
    return (sel == 18) ? '0 : '1;
  endfunction

  function automatic logic signed [POS_W-1:0] pick_coord();
    logic [31:0] w;
    int c;
    int sel;
    w   = $urandom;
    sel = $urandom_range(9);
    c   = int'($urandom_range(2047)) - 1024;
    if (sel < 6) return c[POS_W-1:0];
    if (sel < 9) return w[POS_W-1:0];
    case ($urandom_range(5))
      0:       return POS_HI;
      1:       return POS_LO;
      2:       return 24'sd32;
      3:       return -24'sd32;
      4:       return 24'sd96;
      default: return -24'sd96;
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] jitter(logic signed [POS_W-1:0] base);
    int d;
    d = int'($urandom_range(160)) - 80;
    return base + d[POS_W-1:0];
  endfunction

  task automatic send(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic send_add(logic [ID_W-1:0] id, logic signed [POS_W-1:0] x,
                          logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
    send(make_request(OP_ADD, id, x, y, z, $urandom_range(1) == 1));
    seen_x = {seen_x, x};
    seen_y = {seen_y, y};
    seen_z = {seen_z, z};
    if (seen_x.size() > POOL_DEPTH) begin
      void'(seen_x.pop_front());
      void'(seen_y.pop_front());
      void'(seen_z.pop_front());
    end
  endtask

  task automatic send_remove(logic [ID_W-1:0] id);
    logic [31:0] w;
    w = $urandom;
    send(make_request(OP_REMOVE, id, w[POS_W-1:0], POS_LO, POS_HI, w[31]));
  endtask

  task automatic send_query(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                            logic signed [POS_W-1:0] z, logic last);
    logic [31:0] w;
    w = $urandom;
    send(make_request(OP_QUERY, w[ID_W-1:0], x, y, z, last));
  endtask

  task automatic send_random_query(logic last);
    int idx;
    if (seen_x.size() > 0 && $urandom_range(9) < 7) begin
      idx = $urandom_range(seen_x.size() - 1);
      send_query(jitter(seen_x[idx]), jitter(seen_y[idx]), jitter(seen_z[idx]), last);
    end else begin
      send_query(pick_coord(), pick_coord(), pick_coord(), last);
    end
  endtask

  task automatic run_phase(int idle, int stall);
    int n;
    int r;
    int add_w;
    int rem_w;
    int len;
    logic [31:0] w;
    idle_pct  = idle;
    stall_pct = stall;
    n = 0;
    while (n < PHASE_ITEMS) begin
      r     = $urandom_range(99);
      add_w = ((n / 20) % 2 == 0) ? 45 : 12;
      rem_w = ((n / 20) % 2 == 0) ? 8 : 38;
      if (r < 4) begin
        w = $urandom;
        send(make_request(OP_UNUSED, w[ID_W-1:0], pick_coord(), pick_coord(), pick_coord(),
                          w[31]));
      end else if (r < 4 + add_w) begin
        send_add(pick_id(), pick_coord(), pick_coord(), pick_coord());
        n++;
      end else if (r < 4 + add_w + rem_w) begin
        send_remove(pick_id());
        n++;
      end else begin
        len = $urandom_range(4, 1);
        for (int k = 0; k < len; k++) begin
          if (k > 0 && $urandom_range(9) == 0) begin
            if ($urandom_range(1) == 1) send_add(pick_id(), pick_coord(), pick_coord(),
                                                 pick_coord());
            else send_remove(pick_id());
            n++;
          end
          send_random_query(k == len - 1 && $urandom_range(19) != 0);
          n++;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_query(24'sd0, 24'sd0, 24'sd0, 1'b1);
    send_add(16'h0000, 24'sd0, 24'sd0, 24'sd0);
    send_add(16'hFFFF, POS_HI, POS_HI, POS_HI);
    send_add(16'h1234, POS_LO, POS_LO, POS_LO);
    send_add(16'h00A5, 24'sd32, 24'sd96, -24'sd32);
    send_add(16'h00A5, 24'sd64, 24'sd64, 24'sd64);
    send(make_request(OP_UNUSED, 16'hFFFF, POS_HI, POS_LO, POS_HI, 1'b1));
    send_query(24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_add(16'h0777, 24'sd128, 24'sd0, 24'sd0);
    send_remove(16'h0000);
    send_query(POS_HI, POS_HI, POS_HI, 1'b1);
    send_query(POS_LO, POS_LO, POS_LO, 1'b1);
    send_remove(16'h4321);
    send_query(24'sd64, 24'sd64, 24'sd64, 1'b1);
    send_remove(16'h00A5);
    send_query(-24'sd100, 24'sd5000, 24'sd77, 1'b1);
    send_query(POS_HI, POS_LO, 24'sd0, 1'b1);
    send_query(24'sd128, -24'sd160, 24'sd160, 1'b1);

    run_phase(0, 0);
    run_phase(87, 0);
    run_phase(0, 87);
    run_phase(8, 8);

    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** grid_proximity_tracker_core: PASSED **");
    end else begin
      $display("** grid_proximity_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule
